// ===== design/hex_address_value_line_parser_macros.svh =====
// Assertion macros shared by the hex address/value line parser RTL.
`ifndef HEX_ADDRESS_VALUE_LINE_PARSER_MACROS_SVH
`define HEX_ADDRESS_VALUE_LINE_PARSER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define HAVLP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define HAVLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/havlp_pkg.sv =====
// Types, character codes and helpers for the hex address/value line parser.
`default_nettype none

package havlp_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
    } t_req;

    typedef struct packed {
        logic        code_ok;
        logic [31:0] address;
        logic [31:0] value;
        logic [1:0]  width;
    } t_rsp;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_HASH  = 8'h23;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_EQUAL = 8'h3D;
    localparam logic [7:0] CHR_X_LO  = 8'h78;
    localparam logic [7:0] CHR_X_UP  = 8'h58;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_A_LO  = 8'h61;
    localparam logic [7:0] CHR_F_LO  = 8'h66;
    localparam logic [7:0] CHR_A_UP  = 8'h41;
    localparam logic [7:0] CHR_F_UP  = 8'h46;

    localparam logic [3:0] HEX_TEN = 4'd10;

    localparam logic [2:0] TOKEN_LEN_MAX    = 3'd5;
    localparam logic [2:0] TOKEN_LEN_PREFIX = 3'd2;
    localparam logic [2:0] TOKEN_LEN_BYTE   = 3'd2;
    localparam logic [2:0] TOKEN_LEN_WORD   = 3'd4;

    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_WORD = 2'd1;
    localparam logic [1:0] WIDTH_LONG = 2'd2;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHR_SPACE) || (c >= CHR_TAB && c <= CHR_CR);
    endfunction

    function automatic logic is_comment(input logic [7:0] c);
        return (c == CHR_HASH) || (c == CHR_SEMI);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return is_blank(c) || (c == CHR_COLON) || (c == CHR_EQUAL);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CHR_0 && c <= CHR_9) || (c >= CHR_A_LO && c <= CHR_F_LO) ||
               (c >= CHR_A_UP && c <= CHR_F_UP);
    endfunction

    // Digit value of a hex character; meaningless for other codes.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CHR_0 && c <= CHR_9) begin
            d = c - CHR_0;
        end else if (c >= CHR_A_LO && c <= CHR_F_LO) begin
            d = c - CHR_A_LO + {4'd0, HEX_TEN};
        end else begin
            d = c - CHR_A_UP + {4'd0, HEX_TEN};
        end
        return d[3:0];
    endfunction

    function automatic logic [1:0] width_code(input logic [2:0] len);
        logic [1:0] w;
        if (len <= TOKEN_LEN_BYTE) begin
            w = WIDTH_BYTE;
        end else if (len <= TOKEN_LEN_WORD) begin
            w = WIDTH_WORD;
        end else begin
            w = WIDTH_LONG;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/hex_address_value_line_parser.sv =====
// Hex address/value line parser: byte-stream parse state and result register.
//
// Send a text line as requests of one character each (line_end = 0), then one
// request with line_end = 1. Only the line_end request produces a response:
// code_ok, address, value and a width code (byte, word, long, from the value
// token's length including any 0x prefix). A failed line returns code_ok = 0
// with all other fields zero. Both channels use valid/ready; a request moves
// when valid and ready are both high at a rising edge of i_clk.
// Timing: one request per cycle unless stalled. Each character updates the parse
// state at the edge that accepts it; the response of a line_end request is
// valid in the output register right after that edge.
// The single output register sets the rate: a new request is taken while the
// response register is empty or drained in the same cycle.
// Reset: i_rst_n low (synchronous) returns the parser to the leading-blank
// phase with empty accumulators and drops any pending response.
// Stall: while a response waits and i_out_ready is low, o_in_ready is low,
// so every request, character or line end, holds until the response is taken.
`default_nettype none

`include "hex_address_value_line_parser_macros.svh"

module hex_address_value_line_parser
    import havlp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_ready,
    input  wire t_req i_req,
    output      logic o_out_valid,
    input  wire logic i_out_ready,
    output      t_rsp o_rsp
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_ADDR,
        PH_SEP,
        PH_VALUE,
        PH_TRAIL,
        PH_FAIL,
        PH_COMMENT
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_value, n_value;
    logic [2:0]  r_tok_len, n_tok_len;
    logic        r_tok_zero, n_tok_zero;
    logic        r_tok_digit, n_tok_digit;
    logic        r_out_valid;
    t_rsp        r_rsp, n_rsp;

    logic        in_acc;
    logic [7:0]  c;
    logic        c_hex, c_prefix, c_tok;
    logic        on_addr;
    logic [31:0] tok_acc, tok_acc_next;
    logic        line_ok;

    // Take a request whenever the response register is free or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign c          = i_req.character;

    // Token character: hex digit, or the x of a 0x prefix right after a leading 0.
    assign c_hex    = is_hex(c);
    assign c_prefix = ((c == CHR_X_LO) || (c == CHR_X_UP)) && (r_tok_len == 3'd1) && r_tok_zero;
    assign c_tok    = c_hex || c_prefix;

    // Address token while leading or in the address; the value token otherwise.
    assign on_addr      = (r_phase == PH_LEAD) || (r_phase == PH_ADDR);
    assign tok_acc      = on_addr ? r_addr : r_value;
    assign tok_acc_next = {tok_acc[27:0], hex_digit(c)};

    assign line_ok = ((r_phase == PH_VALUE) && r_tok_digit) ||
                     (r_phase == PH_TRAIL) || (r_phase == PH_COMMENT);

    always_comb begin
        logic tok_write;

        n_phase     = r_phase;
        n_addr      = r_addr;
        n_value     = r_value;
        n_tok_len   = r_tok_len;
        n_tok_zero  = r_tok_zero;
        n_tok_digit = r_tok_digit;
        tok_write   = 1'b0;

        n_rsp.code_ok = line_ok;
        n_rsp.address = line_ok ? r_addr : '0;
        n_rsp.value   = line_ok ? r_value : '0;
        n_rsp.width   = line_ok ? width_code(r_tok_len) : WIDTH_BYTE;

        if (i_req.line_end) begin
            // End of line: clear all parse state for the next line.
            n_phase     = PH_LEAD;
            n_addr      = '0;
            n_value     = '0;
            n_tok_len   = '0;
            n_tok_zero  = 1'b0;
            n_tok_digit = 1'b0;
        end else begin
            case (r_phase)
                PH_LEAD: begin
                    if (!is_blank(c)) begin
                        if (is_comment(c) || is_sep(c) || !c_tok) begin
                            n_phase = PH_FAIL;
                        end else begin
                            n_phase   = PH_ADDR;
                            tok_write = 1'b1;
                        end
                    end
                end
                PH_ADDR: begin
                    if (is_comment(c)) begin
                        n_phase = PH_FAIL;
                    end else if (is_sep(c)) begin
                        n_phase     = r_tok_digit ? PH_SEP : PH_FAIL;
                        n_tok_len   = '0;
                        n_tok_zero  = 1'b0;
                        n_tok_digit = 1'b0;
                    end else if (c_tok) begin
                        tok_write = 1'b1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_SEP: begin
                    if (!is_sep(c)) begin
                        if (is_comment(c) || !c_tok) begin
                            n_phase = PH_FAIL;
                        end else begin
                            n_phase   = PH_VALUE;
                            tok_write = 1'b1;
                        end
                    end
                end
                PH_VALUE: begin
                    if (is_comment(c)) begin
                        n_phase = r_tok_digit ? PH_COMMENT : PH_FAIL;
                    end else if (is_blank(c)) begin
                        n_phase = r_tok_digit ? PH_TRAIL : PH_FAIL;
                    end else if (c_tok) begin
                        tok_write = 1'b1;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_TRAIL: begin
                    if (is_comment(c)) begin
                        n_phase = PH_COMMENT;
                    end else if (!is_blank(c)) begin
                        n_phase = PH_FAIL;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (tok_write) begin
                if (c_hex) begin
                    if (on_addr) begin
                        n_addr = tok_acc_next;
                    end else begin
                        n_value = tok_acc_next;
                    end
                    if ((r_tok_len == 3'd0) && (c == CHR_0)) begin
                        n_tok_zero = 1'b1;
                    end
                    n_tok_digit = 1'b1;
                    if (r_tok_len < TOKEN_LEN_MAX) begin
                        n_tok_len = r_tok_len + 3'd1;
                    end
                end else begin
                    // Prefix: digits must follow it.
                    n_tok_digit = 1'b0;
                    n_tok_len   = TOKEN_LEN_PREFIX;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_addr      <= '0;
            r_value     <= '0;
            r_tok_len   <= '0;
            r_tok_zero  <= 1'b0;
            r_tok_digit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase     <= n_phase;
                r_addr      <= n_addr;
                r_value     <= n_value;
                r_tok_len   <= n_tok_len;
                r_tok_zero  <= n_tok_zero;
                r_tok_digit <= n_tok_digit;
            end
            // Load the response on a line end, drop it once taken.
            if (in_acc && i_req.line_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc && i_req.line_end) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    `HAVLP_ASSERT_NEXT(a_line_end_clears, i_clk, i_rst_n, in_acc && i_req.line_end,
        r_phase == PH_LEAD && r_tok_len == 3'd0 && r_addr == 32'd0, "state not cleared")
    `HAVLP_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_rsp.code_ok,
        o_rsp.address == 32'd0 && o_rsp.value == 32'd0 && o_rsp.width == WIDTH_BYTE,
        "failed line carries nonzero fields")
    `HAVLP_ASSERT_NEXT(a_no_spurious_rsp, i_clk, i_rst_n,
        in_acc && !i_req.line_end && !o_out_valid, !o_out_valid, "response without line end")
    `HAVLP_ASSERT_SAME(a_digit_has_len, i_clk, i_rst_n, r_tok_digit,
        r_tok_len != 3'd0 && r_tok_len <= TOKEN_LEN_MAX, "token length inconsistent")

endmodule

`default_nettype wire
